FILE: sv/sbq_pkg.sv
`timescale 1ns / 1ps

package sbq_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int SCALE_BITS      = 16;
  localparam int COEF_BITS       = 24;
  localparam int FRAC_SHIFT      = 22;
  localparam int MAXV_BITS       = 26;
  localparam int OUT_BITS        = 32;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 26;

  localparam logic [CFG_IDX_BITS-1:0] REG_SCALE_FACTOR  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FILTER_ENABLE = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_B0       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_A1       = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_A2       = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_VALUE     = 3'd5;

  localparam logic [SCALE_BITS-1:0] SCALE_RESET = 16'd256;
  localparam logic [MAXV_BITS-1:0]  MAXV_RESET  = 26'h3FFFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SUM,
    ST_MAC,
    ST_ROUND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic msb;
  } mac_ctrl_t;

endpackage

FILE: sv/sbq_mac.sv
`timescale 1ns / 1ps

module sbq_mac import sbq_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  mac_ctrl_t                         ctrl,
  input  logic signed [COEF_BITS-1:0]       coef_b0,
  input  logic signed [COEF_BITS-1:0]       coef_a1,
  input  logic signed [COEF_BITS-1:0]       coef_a2,
  input  logic [SAMPLE_BITS+SCALE_BITS+1:0] x_sum,
  input  logic signed [OUT_BITS-1:0]        y1,
  input  logic signed [OUT_BITS-1:0]        y2,
  output logic signed [OUT_BITS-1:0]        y
);

  localparam int SW     = SAMPLE_BITS + SCALE_BITS + 2;
  localparam int VW     = (SW > OUT_BITS) ? SW : OUT_BITS;
  localparam int ACC_W  = VW + COEF_BITS + 2;
  localparam int QW     = ACC_W - FRAC_SHIFT;

  logic [COEF_BITS-1:0]    b0_sh;
  logic [COEF_BITS-1:0]    a1_sh;
  logic [COEF_BITS-1:0]    a2_sh;
  logic [ACC_W-1:0]        s_ext;
  logic [ACC_W-1:0]        y1_ext;
  logic [ACC_W-1:0]        y2_ext;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] rnd;
  logic signed [QW-1:0]    q;

  // horner form, coefficient bits msb first; the sign bit carries negative weight
  always_comb begin
    term = '0;
    if (b0_sh[COEF_BITS-1]) term = term + s_ext;
    if (a1_sh[COEF_BITS-1]) term = term + y1_ext;
    if (a2_sh[COEF_BITS-1]) term = term + y2_ext;
    if (ctrl.msb) begin
      acc_next = (acc <<< 1) - term;
    end else begin
      acc_next = (acc <<< 1) + term;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      b0_sh  <= coef_b0;
      a1_sh  <= coef_a1;
      a2_sh  <= coef_a2;
      s_ext  <= ACC_W'(x_sum);
      y1_ext <= {{(ACC_W-OUT_BITS){y1[OUT_BITS-1]}}, y1};
      y2_ext <= {{(ACC_W-OUT_BITS){y2[OUT_BITS-1]}}, y2};
      acc    <= '0;
    end else if (ctrl.step) begin
      b0_sh <= b0_sh << 1;
      a1_sh <= a1_sh << 1;
      a2_sh <= a2_sh << 1;
      acc   <= acc_next;
    end
  end

  // round half up, floor shift, then clamp to 32 bits
  always_comb begin
    rnd = acc + (ACC_W'(1) << (FRAC_SHIFT - 1));
    q   = QW'(rnd >>> FRAC_SHIFT);
    if (!q[QW-1] && (q[QW-2:OUT_BITS-1] != '0)) begin
      y = {1'b0, {(OUT_BITS-1){1'b1}}};
    end else if (q[QW-1] && (q[QW-2:OUT_BITS-1] != '1)) begin
      y = {1'b1, {(OUT_BITS-1){1'b0}}};
    end else begin
      y = q[OUT_BITS-1:0];
    end
  end

endmodule

FILE: sv/scaled_sample_biquad_lowpass.sv
`timescale 1ns / 1ps
// scaled sample biquad low-pass
// input channel: in_valid/in_ready with one sample per transaction
// output channel: out_valid/out_ready with filtered_value and over_limit
// config channel: cfg_valid/cfg_ready, cfg_index selects the register,
//   cfg_data holds the value; cfg_ready is always high, unknown indexes are dropped
// the sample is scaled by a bit-serial shift-add, one sample bit per cycle,
// then the biquad sum runs bit-serially over the 24 coefficient bits, one bit
// of all three coefficients per cycle; bypass mode skips the coefficient steps
// one item is in work at a time, so a new sample is taken only after the
// last one has reached the output register
// a finished result sits in the output register; the next sample is taken
// while it waits, and the datapath holds its result if the register is
// still full when the next one is done
// reset clears the histories, the config registers to their defaults and
// drops any transaction in work
module scaled_sample_biquad_lowpass import sbq_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [SAMPLE_BITS-1:0]     sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_BITS-1:0] filtered_value,
  output logic                       over_limit,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int XW    = SAMPLE_BITS + SCALE_BITS;
  localparam int SW    = XW + 2;
  localparam int CNT_N = (SAMPLE_BITS > COEF_BITS) ? SAMPLE_BITS : COEF_BITS;
  localparam int CNT_W = $clog2(CNT_N);

  state_t state;
  state_t state_next;

  logic [SCALE_BITS-1:0]       scale_factor;
  logic                        filter_enable;
  logic signed [COEF_BITS-1:0] coef_b0;
  logic signed [COEF_BITS-1:0] coef_a1;
  logic signed [COEF_BITS-1:0] coef_a2;
  logic [MAXV_BITS-1:0]        max_value;

  logic [XW-1:0]               x1;
  logic [XW-1:0]               x2;
  logic signed [OUT_BITS-1:0]  y1;
  logic signed [OUT_BITS-1:0]  y2;

  logic [SAMPLE_BITS-1:0]      sample_sh;
  logic [XW-1:0]               x;
  logic [SW-1:0]               x_sum;
  logic [CNT_W-1:0]            cnt;
  logic signed [OUT_BITS-1:0]  res_y;
  logic                        res_over;
  logic [OUT_BITS:0]           x_wide;
  logic signed [OUT_BITS-1:0]  x_sat;
  logic signed [OUT_BITS-1:0]  mac_y;
  mac_ctrl_t                   mac_ctrl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor  <= SCALE_RESET;
      filter_enable <= 1'b0;
      coef_b0       <= '0;
      coef_a1       <= '0;
      coef_a2       <= '0;
      max_value     <= MAXV_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCALE_FACTOR:  scale_factor  <= cfg_data[SCALE_BITS-1:0];
        REG_FILTER_ENABLE: filter_enable <= cfg_data[0];
        REG_COEF_B0:       coef_b0       <= cfg_data[COEF_BITS-1:0];
        REG_COEF_A1:       coef_a1       <= cfg_data[COEF_BITS-1:0];
        REG_COEF_A2:       coef_a2       <= cfg_data[COEF_BITS-1:0];
        REG_MAX_VALUE:     max_value     <= cfg_data[MAXV_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mac_ctrl   = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_SCALE;
      end
      ST_SCALE: begin
        if (cnt == CNT_W'(SAMPLE_BITS - 1)) state_next = ST_SUM;
      end
      ST_SUM: begin
        if (filter_enable) begin
          mac_ctrl.load = 1'b1;
          state_next    = ST_MAC;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_MAC: begin
        mac_ctrl.step = 1'b1;
        mac_ctrl.msb  = (cnt == '0);
        if (cnt == CNT_W'(COEF_BITS - 1)) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == ST_SCALE || state == ST_MAC) begin
      if (state_next != state) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end else begin
      cnt <= '0;
    end
  end

  assign x_wide = (OUT_BITS + 1)'(x);
  assign x_sat  = (x_wide > {2'b00, {(OUT_BITS-1){1'b1}}}) ?
                  {1'b0, {(OUT_BITS-1){1'b1}}} : x_wide[OUT_BITS-1:0];

  // shift-add scaling, sample msb first, and capture of the result and over-limit flag
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        sample_sh <= sample;
        x         <= '0;
      end
      ST_SCALE: begin
        sample_sh <= sample_sh << 1;
        x         <= (x << 1) + (sample_sh[SAMPLE_BITS-1] ? XW'(scale_factor) : XW'(0));
      end
      ST_SUM: begin
        res_over <= ((OUT_BITS + 1)'(x) > (OUT_BITS + 1)'(max_value));
        res_y    <= x_sat;
      end
      ST_ROUND: begin
        res_y <= mac_y;
      end
      default: ;
    endcase
  end

  assign x_sum = SW'(x) + {1'b0, x1, 1'b0} + SW'(x2);

  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= '0;
      x2 <= '0;
      y1 <= '0;
      y2 <= '0;
    end else if (state == ST_ROUND) begin
      x2 <= x1;
      x1 <= x;
      y2 <= y1;
      y1 <= mac_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      filtered_value <= res_y;
      over_limit     <= res_over;
    end
  end

  sbq_mac #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mac (
    .clk     (clk),
    .ctrl    (mac_ctrl),
    .coef_b0 (coef_b0),
    .coef_a1 (coef_a1),
    .coef_a2 (coef_a2),
    .x_sum   (x_sum),
    .y1      (y1),
    .y2      (y2),
    .y       (mac_y)
  );

endmodule
